/* src/llist_pkg.sv */
package llist_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int PTR_W    = IDX_W + 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OP_W     = 3;
   localparam int ST_W     = 2;
   localparam int POS_W    = 6;

   // pointer with top bit set means null
   localparam logic [PTR_W-1:0] PTR_NIL = PTR_W'(1) << IDX_W;

   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd2;
   localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd5;
   localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] match_key;
   } req_item_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] removed_value;
      logic [POS_W-1:0]        found_position;
   } rsp_item_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } val_port_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [PTR_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } lnk_port_type;

endpackage

/* src/llist_ram.sv */
module llist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/llist_ctrl.sv */
module llist_ctrl
   import llist_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_item_type     req_data,
   output logic             busy,
   output logic             res_valid,
   output rsp_item_type     res_data,
   input  logic             res_take,
   output val_port_type     val_port,
   input  logic [VAL_W-1:0] val_rd,
   output lnk_port_type     lnk_port,
   input  logic [PTR_W-1:0] lnk_rd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_WALK     = 3'd1;
   localparam logic [2:0] S_ALLOC    = 3'd2;
   localparam logic [2:0] S_ALLOC_WR = 3'd3;
   localparam logic [2:0] S_LINK2    = 3'd4;
   localparam logic [2:0] S_FREE     = 3'd5;
   localparam logic [2:0] S_UNLINK   = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [VAL_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] hwm_ff, hwm_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [IDX_W-1:0] new_ff, new_in;
   logic             chain_ff, chain_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   rsp_item_type     res_ff, res_in;

   logic             list_empty;
   logic             list_full;
   logic [PTR_W-1:0] new_ptr;

   assign list_empty = head_ff[IDX_W];
   assign list_full  = (count_ff == CNT_W'(CAPACITY));
   assign new_ptr    = {1'b0, new_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      key_in   = key_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      hwm_in   = hwm_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      next_in  = next_ff;
      new_in   = new_ff;
      chain_in = chain_ff;
      pos_in   = pos_ff;
      res_in   = res_ff;

      val_port.wr_en   = 1'b0;
      val_port.wr_addr = new_ff;
      val_port.wr_data = val_ff;
      val_port.rd_addr = head_ff[IDX_W-1:0];
      lnk_port.wr_en   = 1'b0;
      lnk_port.wr_addr = new_ff;
      lnk_port.wr_data = PTR_NIL;
      lnk_port.rd_addr = head_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.op;
               val_in  = req_data.value;
               key_in  = req_data.match_key;
               cur_in  = head_ff;
               prev_in = PTR_NIL;
               pos_in  = CNT_W'(1);
               res_in.status         = ST_OK;
               res_in.removed_value  = '0;
               res_in.found_position = '0;
               state_in = S_DONE;
               case (req_data.op)
                  OP_CLEAR: begin
                     head_in  = PTR_NIL;
                     tail_in  = PTR_NIL;
                     free_in  = PTR_NIL;
                     hwm_in   = '0;
                     count_in = '0;
                  end
                  OP_INS_HEAD, OP_INS_TAIL: begin
                     cur_in = tail_ff;
                     if (list_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_INS_AFTER: begin
                     if (list_empty) begin
                        res_in.status = ST_EMPTY;
                     end else if (list_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_DEL_HEAD, OP_DEL_TAIL, OP_SEARCH: begin
                     if (list_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // read data belongs to cur_ff; next node is read in the same cycle
         S_WALK: begin
            val_port.rd_addr = lnk_rd[IDX_W-1:0];
            lnk_port.rd_addr = lnk_rd[IDX_W-1:0];
            cur_in  = lnk_rd;
            prev_in = cur_ff;
            pos_in  = pos_ff + CNT_W'(1);
            case (op_ff)
               OP_SEARCH: begin
                  if (val_rd == val_ff) begin
                     res_in.found_position = POS_W'(pos_ff);
                     state_in = S_DONE;
                  end else if (lnk_rd[IDX_W]) begin
                     res_in.status = ST_NOT_FOUND;
                     state_in = S_DONE;
                  end
               end
               OP_INS_AFTER: begin
                  if (val_rd == key_ff) begin
                     next_in  = lnk_rd;
                     cur_in   = cur_ff;
                     state_in = S_ALLOC;
                  end else if (lnk_rd[IDX_W]) begin
                     res_in.status = ST_NOT_FOUND;
                     state_in = S_DONE;
                  end
               end
               OP_DEL_HEAD: begin
                  res_in.removed_value = val_rd;
                  head_in = lnk_rd;
                  if (lnk_rd[IDX_W]) begin
                     tail_in = PTR_NIL;
                  end
                  cur_in   = cur_ff;
                  state_in = S_FREE;
               end
               OP_DEL_TAIL: begin
                  if (lnk_rd[IDX_W]) begin
                     res_in.removed_value = val_rd;
                     cur_in   = cur_ff;
                     prev_in  = prev_ff;
                     state_in = S_FREE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // freed nodes first, then never-used ones from the fill mark
         S_ALLOC: begin
            if (!free_ff[IDX_W]) begin
               lnk_port.rd_addr = free_ff[IDX_W-1:0];
               new_in   = free_ff[IDX_W-1:0];
               chain_in = 1'b1;
            end else begin
               new_in   = hwm_ff[IDX_W-1:0];
               hwm_in   = hwm_ff + CNT_W'(1);
               chain_in = 1'b0;
            end
            state_in = S_ALLOC_WR;
         end

         S_ALLOC_WR: begin
            if (chain_ff) begin
               free_in = lnk_rd;
            end
            val_port.wr_en = 1'b1;
            count_in       = count_ff + CNT_W'(1);
            lnk_port.wr_en = 1'b1;
            state_in       = S_DONE;
            case (op_ff)
               OP_INS_HEAD: begin
                  lnk_port.wr_data = head_ff;
                  head_in = new_ptr;
                  if (list_empty) begin
                     tail_in = new_ptr;
                  end
               end
               OP_INS_TAIL: begin
                  lnk_port.wr_data = PTR_NIL;
                  if (list_empty) begin
                     head_in = new_ptr;
                     tail_in = new_ptr;
                  end else begin
                     state_in = S_LINK2;
                  end
               end
               OP_INS_AFTER: begin
                  lnk_port.wr_data = next_ff;
                  state_in = S_LINK2;
               end
               default: begin
               end
            endcase
         end

         S_LINK2: begin
            lnk_port.wr_en   = 1'b1;
            lnk_port.wr_addr = cur_ff[IDX_W-1:0];
            lnk_port.wr_data = new_ptr;
            if (cur_ff == tail_ff) begin
               tail_in = new_ptr;
            end
            state_in = S_DONE;
         end

         S_FREE: begin
            lnk_port.wr_en   = 1'b1;
            lnk_port.wr_addr = cur_ff[IDX_W-1:0];
            lnk_port.wr_data = free_ff;
            free_in  = cur_ff;
            count_in = count_ff - CNT_W'(1);
            state_in = S_DONE;
            if (op_ff == OP_DEL_TAIL) begin
               if (!prev_ff[IDX_W]) begin
                  state_in = S_UNLINK;
               end else begin
                  head_in = PTR_NIL;
                  tail_in = PTR_NIL;
               end
            end
         end

         S_UNLINK: begin
            lnk_port.wr_en   = 1'b1;
            lnk_port.wr_addr = prev_ff[IDX_W-1:0];
            lnk_port.wr_data = PTR_NIL;
            tail_in  = prev_ff;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= PTR_NIL;
         tail_ff  <= PTR_NIL;
         free_ff  <= PTR_NIL;
         hwm_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         hwm_ff   <= hwm_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      val_ff   <= val_in;
      key_ff   <= key_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      next_ff  <= next_in;
      new_ff   <= new_in;
      chain_ff <= chain_in;
      pos_ff   <= pos_in;
      res_ff   <= res_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

`ifndef SYNTHESIS
   a_count_le_hwm: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= hwm_ff) && (hwm_ff <= CNT_W'(CAPACITY)))
      else $error("node count exceeds fill mark or capacity");

   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_ff[IDX_W] == (count_ff == '0)))
      else $error("head pointer disagrees with node count");

   a_head_vs_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (head_ff[IDX_W] == tail_ff[IDX_W]))
      else $error("head and tail disagree on empty list");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC && free_ff[IDX_W]) |-> (hwm_ff < CNT_W'(CAPACITY)))
      else $error("allocation with no free node");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_take) |=> (state_ff == S_DONE) && $stable(res_ff))
      else $error("pending result lost");
`endif

endmodule

/* src/linked_list_engine.sv */
// Clear, unused opcodes and rejected requests go from the done state to the output register;
// head/tail inserts allocate and write a node, and a tail insert also links the old tail;
// insert-after, delete and search walk up to CAPACITY nodes, one node per cycle.
// Throughput: one item at a time; the walk is paced by the single read port of the node store.
// Reset (synchronous, active high) empties the list at once; no memory sweep is needed,
// never-used nodes are handed out from a fill mark.
module linked_list_engine
   import llist_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // controller <-> node store
   val_port_type     val_port;
   lnk_port_type     lnk_port;
   logic [VAL_W-1:0] val_rd;
   logic [PTR_W-1:0] lnk_rd;

   logic             busy;
   logic             res_valid;
   rsp_item_type     res_data;
   logic             res_take;

   // output register: a finished result moves here when the slot is
   // empty or being drained this cycle
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   llist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .busy      (busy),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .val_port  (val_port),
      .val_rd    (val_rd),
      .lnk_port  (lnk_port),
      .lnk_rd    (lnk_rd)
   );

   // node values
   llist_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_port.wr_en),
      .wr_addr (val_port.wr_addr),
      .wr_data (val_port.wr_data),
      .rd_addr (val_port.rd_addr),
      .rd_data (val_rd)
   );

   // node links, also used to chain freed nodes
   llist_ram #(
      .WIDTH (PTR_W),
      .DEPTH (CAPACITY)
   ) u_lnk_ram (
      .clock   (clock),
      .wr_en   (lnk_port.wr_en),
      .wr_addr (lnk_port.wr_addr),
      .wr_data (lnk_port.wr_data),
      .rd_addr (lnk_port.rd_addr),
      .rd_data (lnk_rd)
   );

   assign req_stall = busy;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
